// File: design/epa_pkg.sv
// Shared constants, formula codes and cell payload types for the ellipse
// perimeter approximation block. No dependencies.
package epa_pkg;

    localparam int AXIS_FRAC_BITS = 8;
    localparam int OUT_FRAC_BITS  = 16;

    localparam int AXIS_W      = 16;
    localparam int PERIM_W     = 27;
    localparam int ECC_W       = 17;
    localparam int CFG_W       = 3;
    localparam int S_TDATA_W   = 2 * AXIS_W;
    localparam int M_TDATA_W   = ((PERIM_W + ECC_W + 7) / 8) * 8;
    localparam int M_TUSER_W   = 2;

    // divider cells: one quotient bit per cell
    localparam int DIV_STEPS   = 32;
    localparam int DIV_W       = 39;
    // square root cells: one root bit per cell
    localparam int SQRT_STEPS  = 32;
    localparam int SQRT_XW     = 2 * SQRT_STEPS;
    localparam int SQRT_RW     = SQRT_STEPS + 2;

    localparam int SH_FACTOR   = AXIS_FRAC_BITS + 43 - OUT_FRAC_BITS;
    localparam int SH_ROOT     = AXIS_FRAC_BITS + 44 - OUT_FRAC_BITS;

    localparam logic [31:0]        PI_Q30    = 32'hC90F_DAA2;
    localparam logic [31:0]        Q30_ONE   = 32'h4000_0000;
    localparam logic [PERIM_W-1:0] PERIM_MAX = '1;

    localparam logic [CFG_W-1:0] FORM_PI_SUM    = 3'd0;
    localparam logic [CFG_W-1:0] FORM_RMS       = 3'd1;
    localparam logic [CFG_W-1:0] FORM_RMS_CORR  = 3'd2;
    localparam logic [CFG_W-1:0] FORM_SERIES    = 3'd3;
    localparam logic [CFG_W-1:0] FORM_RAMANUJAN = 3'd4;
    localparam logic [CFG_W-1:0] FORM_PADE_A    = 3'd5;
    localparam logic [CFG_W-1:0] FORM_PADE_B    = 3'd6;
    localparam logic [CFG_W-1:0] FORM_ROOT      = 3'd7;

    typedef struct packed {
        logic                 vld;
        logic [DIV_W-1:0]     rem;
        logic [DIV_W-1:0]     den;
        logic [DIV_STEPS-1:0] num;
        logic [DIV_STEPS-1:0] quot;
    } t_div;

    typedef struct packed {
        logic                  vld;
        logic [SQRT_XW-1:0]    rad;
        logic [SQRT_RW-1:0]    rem;
        logic [SQRT_STEPS-1:0] root;
    } t_sqrt;

endpackage

// File: design/epa_div_cell.sv
// One restoring-division step: shifts in a numerator bit, emits a quotient bit.
// Depends on epa_pkg.
module epa_div_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  epa_pkg::t_div i_d,
    output epa_pkg::t_div o_q
);

    logic [epa_pkg::DIV_W:0] w_trial;
    logic [epa_pkg::DIV_W:0] w_diff;
    logic                    w_ge;
    epa_pkg::t_div           n_q;
    epa_pkg::t_div           r_q;

    always_comb begin
        w_trial  = {i_d.rem, i_d.num[epa_pkg::DIV_STEPS-1]};
        w_diff   = w_trial - {1'b0, i_d.den};
        w_ge     = (w_trial >= {1'b0, i_d.den});
        n_q      = i_d;
        n_q.rem  = w_ge ? w_diff[epa_pkg::DIV_W-1:0] : w_trial[epa_pkg::DIV_W-1:0];
        n_q.num  = {i_d.num[epa_pkg::DIV_STEPS-2:0], 1'b0};
        n_q.quot = {i_d.quot[epa_pkg::DIV_STEPS-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.vld <= 1'b0;
        end else if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

// File: design/epa_sqrt_cell.sv
// One digit-by-digit square root step: brings down two radicand bits,
// emits one root bit. Depends on epa_pkg.
module epa_sqrt_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  epa_pkg::t_sqrt i_d,
    output epa_pkg::t_sqrt o_q
);

    logic [epa_pkg::SQRT_RW+1:0] w_trial;
    logic [epa_pkg::SQRT_RW+1:0] w_test;
    logic [epa_pkg::SQRT_RW+1:0] w_diff;
    logic                        w_ge;
    epa_pkg::t_sqrt              n_q;
    epa_pkg::t_sqrt              r_q;

    always_comb begin
        w_trial  = {i_d.rem, i_d.rad[epa_pkg::SQRT_XW-1 -: 2]};
        w_test   = {{(epa_pkg::SQRT_RW - epa_pkg::SQRT_STEPS){1'b0}}, i_d.root, 2'b01};
        w_diff   = w_trial - w_test;
        w_ge     = (w_trial >= w_test);
        n_q      = i_d;
        n_q.rem  = w_ge ? w_diff[epa_pkg::SQRT_RW-1:0] : w_trial[epa_pkg::SQRT_RW-1:0];
        n_q.rad  = {i_d.rad[epa_pkg::SQRT_XW-3:0], 2'b00};
        n_q.root = {i_d.root[epa_pkg::SQRT_STEPS-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.vld <= 1'b0;
        end else if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

// File: design/ellipse_perimeter_approx.sv
// Ellipse perimeter approximation, eight selectable formulas, fully pipelined.
// Throughput: one beat per cycle while the skid entry is free. The pipe holds three
// 32-cell chains (ratio divider, square root, factor divider).
// A two-entry output stage (register plus skid) keeps input open while a result waits.
// Reset (i_rst_n low, synchronous) clears all valid bits and selects Ramanujan II.
// Depends on epa_pkg, epa_div_cell, epa_sqrt_cell.
module ellipse_perimeter_approx (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input beats: [15:0] semi_axis_a, [31:16] semi_axis_b
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [epa_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // result beats: [26:0] perimeter, [43:27] eccentricity_term, [47:44] zero
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [epa_pkg::M_TDATA_W-1:0]  o_m_tdata,
    // [0] degenerate, [1] saturated
    output logic [epa_pkg::M_TUSER_W-1:0]  o_m_tuser,
    // formula_select write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [epa_pkg::CFG_W-1:0]      i_cfg_data
);

    typedef struct packed {
        logic        deg;
        logic [31:0] base;
        logic [63:0] x12;
    } t_ctx1;

    typedef struct packed {
        logic        deg;
        logic [31:0] base;
        logic [30:0] h;
        logic [30:0] h2;
        logic [30:0] t;
    } t_ctx2;

    typedef struct packed {
        logic        deg;
        logic [31:0] base;
        logic [30:0] h;
        logic [31:0] root;
        logic [63:0] mp;
    } t_ctx3;

    // ---------------- configuration ----------------
    logic [epa_pkg::CFG_W-1:0] r_cfg;
    logic                      w_cfg12;

    assign o_cfg_ready = 1'b1;
    assign w_cfg12 = (r_cfg == epa_pkg::FORM_RMS) || (r_cfg == epa_pkg::FORM_RMS_CORR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= epa_pkg::FORM_RAMANUJAN;
        end else if (i_cfg_valid) begin
            r_cfg <= i_cfg_data;
        end
    end

    // Whole pipe advances unless the skid entry is occupied.
    logic r_skid_v;
    logic w_en;
    assign w_en       = ~r_skid_v;
    assign o_s_tready = w_en;

    // ---------------- stage 1: capture axes ----------------
    logic                      r_s1_v;
    logic [epa_pkg::AXIS_W-1:0] r_a, r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_en) begin
            r_s1_v <= i_s_tvalid;
            r_a    <= i_s_tdata[epa_pkg::AXIS_W-1:0];
            r_b    <= i_s_tdata[epa_pkg::S_TDATA_W-1:epa_pkg::AXIS_W];
        end
    end

    // ---------------- stage 2: sum, difference, squares, pi*(a+b) ----------------
    logic [epa_pkg::AXIS_W:0]   w_sum;
    logic [epa_pkg::AXIS_W-1:0] w_dif;
    logic                       r_s2_v;
    logic [epa_pkg::AXIS_W:0]   r_sum;
    logic [epa_pkg::AXIS_W-1:0] r_dif;
    logic [31:0]                r_aa, r_bb, r_dd;
    logic [48:0]                r_pis;

    assign w_sum = {1'b0, r_a} + {1'b0, r_b};
    assign w_dif = (r_a >= r_b) ? (r_a - r_b) : (r_b - r_a);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (w_en) begin
            r_s2_v <= r_s1_v;
            r_sum  <= w_sum;
            r_dif  <= w_dif;
            r_aa   <= 32'(r_a) * 32'(r_a);
            r_bb   <= 32'(r_b) * 32'(r_b);
            r_dd   <= 32'(w_dif) * 32'(w_dif);
            r_pis  <= 49'(epa_pkg::PI_Q30) * 49'(w_sum);
        end
    end

    // ---------------- ratio divider: r = round(D*2^31/S) ----------------
    logic [47:0]   w_n1;
    logic [33:0]   w_sq;
    t_ctx1         w_c1_in;
    epa_pkg::t_div w_d1 [epa_pkg::DIV_STEPS+1];
    t_ctx1         r_c1 [epa_pkg::DIV_STEPS];

    assign w_n1 = {1'b0, r_dif, 31'b0} + 48'(r_sum >> 1);
    assign w_sq = 34'(r_aa) + 34'(r_bb);

    always_comb begin
        w_d1[0].vld  = r_s2_v;
        w_d1[0].rem  = epa_pkg::DIV_W'(w_n1[47:32]);
        w_d1[0].den  = epa_pkg::DIV_W'(r_sum);
        w_d1[0].num  = w_n1[31:0];
        w_d1[0].quot = '0;
        w_c1_in.deg  = (r_sum == '0);
        w_c1_in.base = 32'(({1'b0, r_pis} + (50'd1 << 16)) >> 17);
        // radicand for the two RMS forms
        if (r_cfg == epa_pkg::FORM_RMS) begin
            w_c1_in.x12 = 64'(w_sq) << 29;
        end else begin
            w_c1_in.x12 = ((64'(w_sq) << 2) - 64'(r_dd)) << 27;
        end
    end

    for (genvar g = 0; g < epa_pkg::DIV_STEPS; g++) begin : g_div1
        epa_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_d    (w_d1[g]),
            .o_q    (w_d1[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c1[0] <= w_c1_in;
            for (int k = 1; k < epa_pkg::DIV_STEPS; k++) begin
                r_c1[k] <= r_c1[k-1];
            end
        end
    end

    // ---------------- h stages: square r, round, square h ----------------
    logic        r_h1_v, r_h2_v, r_h3_v;
    logic [63:0] r_rr;
    logic [30:0] r_h, r_h3_h, r_t;
    logic [61:0] r_hh;
    t_ctx1       r_h1_c, r_h2_c, r_h3_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h1_v <= 1'b0;
            r_h2_v <= 1'b0;
            r_h3_v <= 1'b0;
        end else if (w_en) begin
            r_h1_v <= w_d1[epa_pkg::DIV_STEPS].vld;
            r_rr   <= 64'(w_d1[epa_pkg::DIV_STEPS].quot) * 64'(w_d1[epa_pkg::DIV_STEPS].quot);
            r_h1_c <= r_c1[epa_pkg::DIV_STEPS-1];
            r_h2_v <= r_h1_v;
            r_h    <= 31'((65'(r_rr) + (65'd1 << 31)) >> 32);
            r_h2_c <= r_h1_c;
            r_h3_v <= r_h2_v;
            r_h3_h <= r_h;
            r_hh   <= 62'(r_h) * 62'(r_h);
            r_t    <= 31'(epa_pkg::Q30_ONE + ((32'(r_h) + 32'd4) >> 3));
            r_h3_c <= r_h2_c;
        end
    end

    // ---------------- square root chain ----------------
    t_ctx2          w_c2_in;
    epa_pkg::t_sqrt w_s [epa_pkg::SQRT_STEPS+1];
    t_ctx2          r_c2 [epa_pkg::SQRT_STEPS];

    always_comb begin
        w_s[0].vld  = r_h3_v;
        w_s[0].rem  = '0;
        w_s[0].root = '0;
        unique case (r_cfg)
            epa_pkg::FORM_RMS, epa_pkg::FORM_RMS_CORR: w_s[0].rad = r_h3_c.x12;
            epa_pkg::FORM_RAMANUJAN:
                w_s[0].rad = ((64'd4 << 30) - 64'(r_h3_h) * 64'd3) << 30;
            epa_pkg::FORM_ROOT:
                w_s[0].rad = ((64'd1 << 30) - 64'(r_h3_h)) << 30;
            default: w_s[0].rad = '0;
        endcase
        w_c2_in.deg  = r_h3_c.deg;
        w_c2_in.base = r_h3_c.base;
        w_c2_in.h    = r_h3_h;
        w_c2_in.h2   = 31'((r_hh + (62'd1 << 29)) >> 30);
        w_c2_in.t    = r_t;
    end

    for (genvar g = 0; g < epa_pkg::SQRT_STEPS; g++) begin : g_sqrt
        epa_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_d    (w_s[g]),
            .o_q    (w_s[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c2[0] <= w_c2_in;
            for (int k = 1; k < epa_pkg::SQRT_STEPS; k++) begin
                r_c2[k] <= r_c2[k-1];
            end
        end
    end

    // ---------------- stage F: factor operands and shared multiply ----------------
    t_ctx2                    w_c2;
    logic [31:0]              w_root;
    logic [epa_pkg::DIV_W-1:0] w_num, w_den;
    logic [31:0]              w_ma, w_mb;
    logic                     r_f_v;
    logic [epa_pkg::DIV_W-1:0] r_f_num, r_f_den;
    t_ctx3                    r_f_c;

    assign w_c2   = r_c2[epa_pkg::SQRT_STEPS-1];
    assign w_root = w_s[epa_pkg::SQRT_STEPS].root;

    always_comb begin
        unique case (r_cfg)
            epa_pkg::FORM_RAMANUJAN: begin
                w_num = epa_pkg::DIV_W'(w_c2.h) * epa_pkg::DIV_W'(3);
                w_den = (epa_pkg::DIV_W'(10) << 30) + epa_pkg::DIV_W'(w_root);
            end
            epa_pkg::FORM_PADE_A: begin
                w_num = (epa_pkg::DIV_W'(64) << 30)
                        - epa_pkg::DIV_W'(w_c2.h2) * epa_pkg::DIV_W'(3);
                w_den = (epa_pkg::DIV_W'(64) << 30) - (epa_pkg::DIV_W'(w_c2.h) << 4);
            end
            epa_pkg::FORM_PADE_B: begin
                w_num = (epa_pkg::DIV_W'(256) << 30)
                        - epa_pkg::DIV_W'(w_c2.h) * epa_pkg::DIV_W'(48)
                        - epa_pkg::DIV_W'(w_c2.h2) * epa_pkg::DIV_W'(21);
                w_den = (epa_pkg::DIV_W'(256) << 30)
                        - epa_pkg::DIV_W'(w_c2.h) * epa_pkg::DIV_W'(112)
                        + epa_pkg::DIV_W'(w_c2.h2) * epa_pkg::DIV_W'(3);
            end
            default: begin
                w_num = '0;
                w_den = epa_pkg::DIV_W'(epa_pkg::Q30_ONE);
            end
        endcase
        // series form squares its term; the RMS forms scale the root by pi
        if (r_cfg == epa_pkg::FORM_SERIES) begin
            w_ma = 32'(w_c2.t);
            w_mb = 32'(w_c2.t);
        end else begin
            w_ma = epa_pkg::PI_Q30;
            w_mb = w_root;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (w_en) begin
            r_f_v      <= w_s[epa_pkg::SQRT_STEPS].vld;
            r_f_num    <= w_num;
            r_f_den    <= w_den;
            r_f_c.deg  <= w_c2.deg;
            r_f_c.base <= w_c2.base;
            r_f_c.h    <= w_c2.h;
            r_f_c.root <= w_root;
            r_f_c.mp   <= 64'(w_ma) * 64'(w_mb);
        end
    end

    // ---------------- factor divider: round(num*2^30/den) ----------------
    logic [69:0]   w_n2;
    epa_pkg::t_div w_d2 [epa_pkg::DIV_STEPS+1];
    t_ctx3         r_c3 [epa_pkg::DIV_STEPS];

    assign w_n2 = (70'(r_f_num) << 30) + 70'(r_f_den >> 1);

    always_comb begin
        w_d2[0].vld  = r_f_v;
        w_d2[0].rem  = epa_pkg::DIV_W'(w_n2[69:32]);
        w_d2[0].den  = r_f_den;
        w_d2[0].num  = w_n2[31:0];
        w_d2[0].quot = '0;
    end

    for (genvar g = 0; g < epa_pkg::DIV_STEPS; g++) begin : g_div2
        epa_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_d    (w_d2[g]),
            .o_q    (w_d2[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c3[0] <= r_f_c;
            for (int k = 1; k < epa_pkg::DIV_STEPS; k++) begin
                r_c3[k] <= r_c3[k-1];
            end
        end
    end

    // ---------------- stage G: pick factor f ----------------
    t_ctx3       w_c3;
    logic [31:0] w_q, w_f;
    logic        r_g_v, r_g_deg;
    logic [31:0] r_g_f, r_g_base;
    logic [28:0] r_g_p12;
    logic [30:0] r_g_h;

    assign w_c3 = r_c3[epa_pkg::DIV_STEPS-1];
    assign w_q  = w_d2[epa_pkg::DIV_STEPS].quot;

    always_comb begin
        unique case (r_cfg)
            epa_pkg::FORM_SERIES:    w_f = 32'((w_c3.mp + (64'd1 << 29)) >> 30);
            epa_pkg::FORM_RAMANUJAN: w_f = epa_pkg::Q30_ONE + w_q;
            epa_pkg::FORM_PADE_A,
            epa_pkg::FORM_PADE_B:    w_f = w_q;
            epa_pkg::FORM_ROOT:
                w_f = 32'((34'(epa_pkg::Q30_ONE) * 34'd3 - 34'(w_c3.root) + 34'd1) >> 1);
            default:                 w_f = epa_pkg::Q30_ONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_v <= 1'b0;
        end else if (w_en) begin
            r_g_v    <= w_d2[epa_pkg::DIV_STEPS].vld;
            r_g_f    <= w_f;
            r_g_p12  <= 29'((65'(w_c3.mp) + (65'd1 << (epa_pkg::SH_ROOT - 1)))
                            >> epa_pkg::SH_ROOT);
            r_g_deg  <= w_c3.deg;
            r_g_base <= w_c3.base;
            r_g_h    <= w_c3.h;
        end
    end

    // ---------------- stage K: pi(a+b) * f ----------------
    logic        r_k_v, r_k_deg;
    logic [63:0] r_k_pf;
    logic [28:0] r_k_p12;
    logic [30:0] r_k_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_v <= 1'b0;
        end else if (w_en) begin
            r_k_v   <= r_g_v;
            r_k_pf  <= 64'(r_g_base) * 64'(r_g_f);
            r_k_p12 <= r_g_p12;
            r_k_deg <= r_g_deg;
            r_k_h   <= r_g_h;
        end
    end

    // ---------------- final rounding, saturation, degenerate override ----------------
    logic [28:0]                  w_pf, w_p;
    logic                         w_sat;
    logic [epa_pkg::PERIM_W-1:0]  w_perim;
    logic [epa_pkg::ECC_W-1:0]    w_ecc;
    logic [epa_pkg::M_TDATA_W-1:0] w_last_data;
    logic [epa_pkg::M_TUSER_W-1:0] w_last_user;
    logic                         w_last_fire;

    always_comb begin
        w_pf    = 29'((65'(r_k_pf) + (65'd1 << (epa_pkg::SH_FACTOR - 1))) >> epa_pkg::SH_FACTOR);
        w_p     = w_cfg12 ? r_k_p12 : w_pf;
        w_sat   = (w_p > 29'(epa_pkg::PERIM_MAX));
        w_perim = w_sat ? epa_pkg::PERIM_MAX : w_p[epa_pkg::PERIM_W-1:0];
        w_ecc   = epa_pkg::ECC_W'((32'(r_k_h) + (32'd1 << 13)) >> 14);
        if (r_k_deg) begin
            w_last_data = '0;
            w_last_user = 2'b01;
        end else begin
            w_last_data = epa_pkg::M_TDATA_W'({w_ecc, w_perim});
            w_last_user = {w_sat, 1'b0};
        end
    end

    assign w_last_fire = r_k_v & w_en;

    // ---------------- output register plus skid entry ----------------
    logic                          r_out_v;
    logic [epa_pkg::M_TDATA_W-1:0] r_out_data, r_skid_data;
    logic [epa_pkg::M_TUSER_W-1:0] r_out_user, r_skid_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || i_m_tready) begin
            // output slot free: drain skid first, else take the pipe head
            if (r_skid_v) begin
                r_out_v    <= 1'b1;
                r_out_data <= r_skid_data;
                r_out_user <= r_skid_user;
                r_skid_v   <= 1'b0;
            end else begin
                r_out_v    <= w_last_fire;
                r_out_data <= w_last_data;
                r_out_user <= w_last_user;
            end
        end else if (w_last_fire) begin
            // output stalled: park the new result
            r_skid_v    <= 1'b1;
            r_skid_data <= w_last_data;
            r_skid_user <= w_last_user;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule

// File: design/epa_checker.sv
// Port-level checks for ellipse_perimeter_approx, bound to the top level.
// Depends on epa_pkg.
module epa_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic [epa_pkg::S_TDATA_W-1:0]  i_s_tdata,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [epa_pkg::M_TDATA_W-1:0]  o_m_tdata,
    input logic [epa_pkg::M_TUSER_W-1:0]  o_m_tuser,
    input logic                           i_cfg_valid,
    input logic                           o_cfg_ready,
    input logic [epa_pkg::CFG_W-1:0]      i_cfg_data
);

    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata == '0) && !o_m_tuser[1])
        else $error("degenerate beat carries nonzero results");

    a_saturated_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1]) |-> (o_m_tdata[26:0] == epa_pkg::PERIM_MAX))
        else $error("saturated beat without clipped perimeter");

    a_ecc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[43:27] <= 17'd65536))
        else $error("eccentricity term above one");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> o_m_tvalid && $stable(o_m_tdata)
                                        && $stable(o_m_tuser))
        else $error("stalled result beat changed");

endmodule

bind ellipse_perimeter_approx epa_checker u_epa_checker (.*);

// File: tb/ellipse_perimeter_approx_test.sv
// Self-checking testbench for ellipse_perimeter_approx: drives axis pairs and
// formula writes, predicts each result bit-exact and checks every beat in order.
// Depends on epa_pkg and the ellipse_perimeter_approx RTL.
module ellipse_perimeter_approx_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_LEN    = 600;   // long receiver hold-off, fills the pipeline
    localparam int DRAIN_WAIT  = 120;   // pipeline latency plus output stage margin
    localparam int WDOG_LIMIT  = 4000;  // cycles without any beat before giving up
    localparam int PHASE_ITEMS = 100;

    typedef struct packed {
        logic [epa_pkg::PERIM_W-1:0] perimeter;
        logic [epa_pkg::ECC_W-1:0]   ecc_term;
        logic                        degenerate;
        logic                        saturated;
    } t_perim_result;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          s_valid = 1'b0;
    logic [epa_pkg::S_TDATA_W-1:0] s_data = '0;
    logic                          m_ready = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic [epa_pkg::CFG_W-1:0]     cfg_data = '0;
    wire                           o_s_tready, o_m_tvalid, o_cfg_ready;
    wire [epa_pkg::M_TDATA_W-1:0]  o_m_tdata;
    wire [epa_pkg::M_TUSER_W-1:0]  o_m_tuser;

    ellipse_perimeter_approx u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_valid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_data),       // [15:0] semi_axis_a, [31:16] semi_axis_b
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_ready),
        .o_m_tdata   (o_m_tdata),    // [26:0] perimeter, [43:27] eccentricity_term
        .o_m_tuser   (o_m_tuser),    // [0] degenerate, [1] saturated
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Mirror of the formula register, updated on each accepted write
    logic [epa_pkg::CFG_W-1:0] formula_now = epa_pkg::FORM_RAMANUJAN;
    t_perim_result    pending_results[$];
    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int hold_seq = 0;
    int fail_count = 0;
    int beats_in = 0;
    int beats_out = 0;
    int degen_seen = 0;
    int stall_cycles = 0;
    bit [7:0] formulas_used = '0;

    // ---------------------------------------------------------------
    // Predictor arithmetic, all in 64-bit unsigned
    // ---------------------------------------------------------------
    function automatic bit [63:0] int_sqrt(bit [63:0] x);
        bit [63:0] res;
        bit [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // round(num * 2^30 / den) done in two steps to stay inside 64 bits
    function automatic bit [63:0] quotient_q30(bit [63:0] num, bit [63:0] den);
        bit [63:0] q, rem, q2;
        q   = (num << 24) / den;
        rem = (num << 24) - q * den;
        q2  = ((rem << 6) + den / 2) / den;
        return (q << 6) + q2;
    endfunction

    function automatic bit [63:0] square_q30(bit [63:0] x);
        return (x * x + (64'd1 << 29)) >> 30;
    endfunction

    function automatic bit [63:0] shift_round(bit [63:0] x, int sh);
        return (x + (64'd1 << (sh - 1))) >> sh;
    endfunction

    function automatic t_perim_result predict_perimeter(logic [epa_pkg::AXIS_W-1:0] ax,
                                                        logic [epa_pkg::AXIS_W-1:0] bx,
                                                        logic [epa_pkg::CFG_W-1:0] form);
        bit [63:0] a, b, s, d, r, h, f, p, base, h2, sq, root, one, pi;
        t_perim_result res;
        a = ax;
        b = bx;
        one = 64'd1 << 30;
        pi = {32'd0, epa_pkg::PI_Q30};
        s = a + b;
        d = (a >= b) ? a - b : b - a;
        res = '0;
        f = one;
        if (s == 0) begin
            res.degenerate = 1'b1;
            return res;
        end
        r = ((d << 31) + s / 2) / s;
        h = (r * r + (64'd1 << 31)) >> 32;
        if (form == epa_pkg::FORM_RMS || form == epa_pkg::FORM_RMS_CORR) begin
            sq = a * a + b * b;
            if (form == epa_pkg::FORM_RMS) root = int_sqrt((2 * sq) << 28);
            else root = int_sqrt((4 * sq - d * d) << 27);
            p = shift_round(pi * root, epa_pkg::SH_ROOT);
        end else begin
            base = (pi * s + (64'd1 << 16)) >> 17;
            h2 = square_q30(h);
            case (form)
                epa_pkg::FORM_SERIES: f = square_q30(one + ((h + 4) >> 3));
                epa_pkg::FORM_RAMANUJAN: begin
                    root = int_sqrt((4 * one - 3 * h) << 30);
                    f = one + quotient_q30(3 * h, 10 * one + root);
                end
                epa_pkg::FORM_PADE_A:
                    f = quotient_q30(64 * one - 3 * h2, 64 * one - 16 * h);
                epa_pkg::FORM_PADE_B: f = quotient_q30(256 * one - 48 * h - 21 * h2,
                                                       256 * one - 112 * h + 3 * h2);
                epa_pkg::FORM_ROOT: begin
                    root = int_sqrt((one - h) << 30);
                    f = (3 * one - root + 1) >> 1;
                end
                default: f = one;
            endcase
            p = shift_round(base * f, epa_pkg::SH_FACTOR);
        end
        if (p > {37'd0, epa_pkg::PERIM_MAX}) begin
            p = {37'd0, epa_pkg::PERIM_MAX};
            res.saturated = 1'b1;
        end
        res.perimeter = p[epa_pkg::PERIM_W-1:0];
        res.ecc_term  = epa_pkg::ECC_W'((h + (64'd1 << 13)) >> 14);
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request
    // ---------------------------------------------------------------
    int hold_seq_seen = 0;
    int hold_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else if (hold_seq != hold_seq_seen) begin
            hold_seq_seen <= hold_seq;
            hold_left <= HOLD_LEN;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // ---------------------------------------------------------------
    // Result checker: compare each output beat with the oldest prediction
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_perim_result exp_r;
        if (i_rst_n && s_valid && !o_s_tready) stall_cycles++;
        if (i_rst_n && o_m_tvalid && m_ready) begin
            beats_out++;
            if (pending_results.size() == 0) begin
                $error("result beat with no prediction pending");
                fail_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_m_tdata[epa_pkg::PERIM_W-1:0] !== exp_r.perimeter) begin
                    $error("perimeter: expected %0d, got %0d",
                           exp_r.perimeter, o_m_tdata[epa_pkg::PERIM_W-1:0]);
                    fail_count++;
                end
                if (o_m_tdata[epa_pkg::PERIM_W+epa_pkg::ECC_W-1:epa_pkg::PERIM_W]
                        !== exp_r.ecc_term) begin
                    $error("eccentricity_term: expected %0d, got %0d", exp_r.ecc_term,
                           o_m_tdata[epa_pkg::PERIM_W+epa_pkg::ECC_W-1:epa_pkg::PERIM_W]);
                    fail_count++;
                end
                if (o_m_tuser[0] !== exp_r.degenerate) begin
                    $error("degenerate: expected %0d, got %0d",
                           exp_r.degenerate, o_m_tuser[0]);
                    fail_count++;
                end
                if (o_m_tuser[1] !== exp_r.saturated) begin
                    $error("saturated: expected %0d, got %0d",
                           exp_r.saturated, o_m_tuser[1]);
                    fail_count++;
                end
                if (exp_r.degenerate) degen_seen++;
            end
        end
    end

    // Watchdog: any beat on any channel resets the count
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_valid && o_s_tready) || (o_m_tvalid && m_ready) || (cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("timeout after %0d quiet cycles", idle_cycles);
            $display("tb: failure");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Shared stimulus tasks
    // ---------------------------------------------------------------
    task automatic send_axes(logic [epa_pkg::AXIS_W-1:0] a, logic [epa_pkg::AXIS_W-1:0] b);
        // insert random gaps on the sender side
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {b, a};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pending_results.push_back(predict_perimeter(a, b, formula_now));
        formulas_used[formula_now] = 1'b1;
        beats_in++;
    endtask

    // Drop valid and wait until every prediction has been consumed
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_formula(logic [epa_pkg::CFG_W-1:0] form);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= form;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        formula_now = form;
    endtask

    function automatic logic [epa_pkg::AXIS_W-1:0] pick_axis();
        case ($urandom_range(3))
            0: return epa_pkg::AXIS_W'($urandom_range(255));     // small values
            1: return epa_pkg::AXIS_W'(1) << $urandom_range(epa_pkg::AXIS_W - 1);
            default: return epa_pkg::AXIS_W'($urandom);
        endcase
    endfunction

    task automatic send_random_pair();
        logic [epa_pkg::AXIS_W-1:0] a, b;
        a = pick_axis();
        case ($urandom_range(7))
            0: b = 0;                                            // one axis zero
            1: b = a;                                            // circle
            2: b = a + epa_pkg::AXIS_W'($urandom_range(3));      // nearly equal
            3: begin a = 0; b = 0; end                           // zero sum
            default: b = pick_axis();
        endcase
        if ($urandom_range(1)) send_axes(a, b);
        else send_axes(b, a);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Extremes and special cases under the reset formula, then under every formula
    task automatic test_directed();
        logic [epa_pkg::AXIS_W-1:0] corner[6] = '{16'h0000, 16'h0001, 16'h0100,
                                                  16'h8000, 16'hFFFE, 16'hFFFF};
        send_axes(16'h0000, 16'h0000);
        send_axes(16'hFFFF, 16'hFFFF);
        send_axes(16'hFFFF, 16'h0000);
        send_axes(16'h0000, 16'h0001);
        send_axes(16'h5555, 16'hAAAA);
        for (int fm = 0; fm < 8; fm++) begin
            write_formula(epa_pkg::CFG_W'(fm));
            foreach (corner[i]) send_axes(corner[i], corner[5 - i]);
            send_axes(16'h0000, 16'h0000);
            send_axes(16'hFFFF, 16'hFFFF);
        end
    endtask

    // Random pairs per formula, cycling the idle mix so gaps hit every stage
    task automatic test_random_formulas();
        logic [epa_pkg::CFG_W-1:0] order[8] = '{epa_pkg::FORM_PI_SUM, epa_pkg::FORM_ROOT,
                                                epa_pkg::FORM_RMS, epa_pkg::FORM_PADE_B,
                                                epa_pkg::FORM_RMS_CORR, epa_pkg::FORM_PADE_A,
                                                epa_pkg::FORM_SERIES,
                                                epa_pkg::FORM_RAMANUJAN};
        int src_mix[4] = '{0, 70, 0, 32};
        int snk_mix[4] = '{0, 0, 70, 32};
        foreach (order[k]) begin
            write_formula(order[k]);
            for (int m = 0; m < 4; m++) begin
                src_idle_pct = src_mix[m];
                snk_stall_pct = snk_mix[m];
                repeat (PHASE_ITEMS / 4) send_random_pair();
            end
        end
        src_idle_pct = 0;
        snk_stall_pct = 0;
    endtask

    // Hold the receiver off for a long stretch while offering back-to-back beats
    task automatic test_backpressure();
        write_formula(epa_pkg::FORM_ROOT);
        hold_seq++;
        repeat (300) send_random_pair();
        drain_results();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_formulas();
        test_backpressure();
        drain_results();
        $display("covered %0d input beats, %0d results (%0d zero-sum), formulas mask %b",
                 beats_in, beats_out, degen_seen, formulas_used);
        $display("input stalled for %0d cycles under output back-pressure", stall_cycles);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: files.f
design/epa_pkg.sv
design/epa_div_cell.sv
design/epa_sqrt_cell.sv
design/ellipse_perimeter_approx.sv
design/epa_checker.sv
tb/ellipse_perimeter_approx_test.sv
